// File: design/sha256_pkg.sv
// shared types, constants and round functions of the sha-256 hash engine
package sha256_pkg;

    localparam int WORD_W   = 32;
    localparam int BITS_W   = 6;
    localparam int SLOT_W   = 4;
    localparam int POS_W    = 10;
    localparam int ROUND_W  = 6;
    localparam int COUNT_W  = 64;
    localparam int BLOCK_N  = 16;
    localparam int CHAIN_N  = 8;

    // padding threshold in bits within a block, last round and last word slot
    localparam logic [POS_W-1:0] LEN_POS   = 10'd448;
    localparam logic [ROUND_W-1:0] LAST_ROUND = 6'd63;
    localparam logic [SLOT_W-1:0]  LAST_SLOT  = 4'd15;

    localparam logic [WORD_W-1:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [WORD_W-1:0] H_INIT [CHAIN_N] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD
    } sha_state_t;

    // what follows the compression in progress
    typedef enum logic [1:0] {
        PH_DATA,
        PH_PREPAD,
        PH_EXTRA,
        PH_FINAL
    } sha_phase_t;

    typedef struct packed {
        logic                wr_word;
        logic                wr_last;
        logic                pad;
        logic                len;
        logic                load;
        logic                round;
        logic [ROUND_W-1:0]  round_idx;
        logic                fold;
        logic                fold_final;
    } sha_cmd_t;

    typedef struct packed {
        logic slot_last;
        logic pos_full;
        logic pos_high;
    } sha_status_t;

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// File: design/sha256_hash_engine.sv
// top level of the sha-256 hash engine: controller and datapath
//
// Input channel (in_valid / in_ready) takes one message word per handshake,
// big-endian, with word_bits and last_word. Words before the last count as
// 32 bits; on the last word only the leading word_bits bits (at most 32) are
// kept. The output channel (out_valid / out_ready) gives the eight digest
// words of a message, one result per last word.
// A word that does not fill the block is written into it and in_ready stays
// high. The word that fills the block starts a compression: a load state, the
// rounds (one round per cycle through a single round unit) and a fold state;
// in_ready stays low from the load through the fold.
// After the last word the controller runs the padding and length states and
// then the final compression. A padding that spills into an extra block
// compresses that block before the length state, and a full last word in the
// final slot first closes its block with a compression.
// The digest sits in its own output register, so new words are taken while
// it waits; only a second finished digest waits for out_ready to take the
// first one. Reset loads the standard initial hash value, clears the block
// and the bit count and drops out_valid.
module sha256_hash_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sha256_pkg::WORD_W-1:0] message_word,
    input  logic [sha256_pkg::BITS_W-1:0] word_bits,
    input  logic                          last_word,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sha256_pkg::WORD_W-1:0] digest_0,
    output logic [sha256_pkg::WORD_W-1:0] digest_1,
    output logic [sha256_pkg::WORD_W-1:0] digest_2,
    output logic [sha256_pkg::WORD_W-1:0] digest_3,
    output logic [sha256_pkg::WORD_W-1:0] digest_4,
    output logic [sha256_pkg::WORD_W-1:0] digest_5,
    output logic [sha256_pkg::WORD_W-1:0] digest_6,
    output logic [sha256_pkg::WORD_W-1:0] digest_7
);

    sha256_pkg::sha_cmd_t          cmd;
    sha256_pkg::sha_status_t       status;
    logic [sha256_pkg::WORD_W-1:0] digest [sha256_pkg::CHAIN_N];

    // sequencing
    sha256_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .last_word (last_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // hashing datapath
    sha256_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .message_word (message_word),
        .word_bits    (word_bits),
        .status       (status),
        .digest       (digest)
    );

    assign digest_0 = digest[0];
    assign digest_1 = digest[1];
    assign digest_2 = digest[2];
    assign digest_3 = digest[3];
    assign digest_4 = digest[4];
    assign digest_5 = digest[5];
    assign digest_6 = digest[6];
    assign digest_7 = digest[7];

endmodule

// File: design/sha256_ctrl.sv
// controller state machine sequencing word loads, padding and compression rounds
module sha256_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   last_word,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  sha256_pkg::sha_status_t status,
    output sha256_pkg::sha_cmd_t    cmd
);

    sha256_pkg::sha_state_t             state_reg, state_next;
    sha256_pkg::sha_phase_t             phase_reg, phase_next;
    logic [sha256_pkg::ROUND_W-1:0]     round_reg, round_next;
    logic                               out_valid_reg, out_valid_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha256_pkg::ST_IDLE;
            phase_reg     <= sha256_pkg::PH_DATA;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == sha256_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        round_next     = round_reg;
        cmd            = '0;
        cmd.round_idx  = round_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (last_word)
                    begin
                        cmd.wr_last = 1'b1;
                        state_next  = sha256_pkg::ST_PAD;
                    end
                    else
                    begin
                        cmd.wr_word = 1'b1;
                        if (status.slot_last)
                        begin
                            phase_next = sha256_pkg::PH_DATA;
                            state_next = sha256_pkg::ST_LOAD;
                        end
                    end
                end
            end
            sha256_pkg::ST_PAD:
            begin
                // a full last word in the final slot closes the block first
                if (status.pos_full)
                begin
                    phase_next = sha256_pkg::PH_PREPAD;
                    state_next = sha256_pkg::ST_LOAD;
                end
                else
                begin
                    cmd.pad = 1'b1;
                    if (status.pos_high)
                    begin
                        phase_next = sha256_pkg::PH_EXTRA;
                        state_next = sha256_pkg::ST_LOAD;
                    end
                    else
                    begin
                        state_next = sha256_pkg::ST_LEN;
                    end
                end
            end
            sha256_pkg::ST_LEN:
            begin
                cmd.len    = 1'b1;
                phase_next = sha256_pkg::PH_FINAL;
                state_next = sha256_pkg::ST_LOAD;
            end
            sha256_pkg::ST_LOAD:
            begin
                cmd.load   = 1'b1;
                round_next = '0;
                state_next = sha256_pkg::ST_ROUND;
            end
            sha256_pkg::ST_ROUND:
            begin
                cmd.round  = 1'b1;
                round_next = round_reg + 1'b1;
                if (round_reg == sha256_pkg::LAST_ROUND)
                begin
                    state_next = sha256_pkg::ST_FOLD;
                end
            end
            sha256_pkg::ST_FOLD:
            begin
                unique case (phase_reg)
                    sha256_pkg::PH_DATA:
                    begin
                        cmd.fold   = 1'b1;
                        state_next = sha256_pkg::ST_IDLE;
                    end
                    sha256_pkg::PH_PREPAD:
                    begin
                        cmd.fold   = 1'b1;
                        state_next = sha256_pkg::ST_PAD;
                    end
                    sha256_pkg::PH_EXTRA:
                    begin
                        cmd.fold   = 1'b1;
                        state_next = sha256_pkg::ST_LEN;
                    end
                    sha256_pkg::PH_FINAL:
                    begin
                        // wait for the output register to be free
                        if (!out_valid_reg || out_ready)
                        begin
                            cmd.fold_final = 1'b1;
                            out_valid_next = 1'b1;
                            state_next     = sha256_pkg::ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = sha256_pkg::ST_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = sha256_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/sha256_dp.sv
// datapath: message block, schedule, round unit, chaining state and digest register
module sha256_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sha256_pkg::sha_cmd_t            cmd,
    input  logic [sha256_pkg::WORD_W-1:0]   message_word,
    input  logic [sha256_pkg::BITS_W-1:0]   word_bits,
    output sha256_pkg::sha_status_t         status,
    output logic [sha256_pkg::WORD_W-1:0]   digest [sha256_pkg::CHAIN_N]
);

    localparam int W = sha256_pkg::WORD_W;
    localparam int N = sha256_pkg::BLOCK_N;
    localparam int C = sha256_pkg::CHAIN_N;

    logic [W-1:0] blk_reg    [N];
    logic [W-1:0] blk_next   [N];
    logic [W-1:0] sched_reg  [N];
    logic [W-1:0] sched_next [N];
    logic [W-1:0] v_reg      [C];
    logic [W-1:0] v_next     [C];
    logic [W-1:0] h_reg      [C];
    logic [W-1:0] h_next     [C];
    logic [W-1:0] digest_reg [C];
    logic [W-1:0] digest_next[C];

    logic [sha256_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [sha256_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    logic [sha256_pkg::POS_W-1:0]   pos_reg, pos_next;

    logic [sha256_pkg::BITS_W-1:0]  bits_clip;
    logic [W-1:0]                   keep_mask;
    logic [sha256_pkg::BITS_W-1:0]  add_bits;
    logic [sha256_pkg::COUNT_W:0]   count_sum;
    logic [W-1:0]                   t1;
    logic [W-1:0]                   t2;
    logic [W-1:0]                   ch;
    logic [W-1:0]                   maj;
    logic [W-1:0]                   w_new;

    // valid-bit count clipped to a word, the mask of kept bits and the new bit count
    always_comb
    begin
        bits_clip = (word_bits > 6'd32) ? 6'd32 : word_bits;
        keep_mask = ~({W{1'b1}} >> bits_clip);
        add_bits  = cmd.wr_last ? bits_clip : 6'd32;
        count_sum = {1'b0, count_reg} + {{(sha256_pkg::COUNT_W - sha256_pkg::BITS_W + 1){1'b0}},
                                          add_bits};
    end

    // one round of the compression and one step of the schedule
    always_comb
    begin
        ch    = v_reg[6] ^ (v_reg[4] & (v_reg[5] ^ v_reg[6]));
        maj   = (v_reg[0] & v_reg[1]) | (v_reg[2] & (v_reg[0] | v_reg[1]));
        t1    = v_reg[7] + sha256_pkg::big_sigma1(v_reg[4]) + ch
              + sha256_pkg::K_TABLE[cmd.round_idx] + sched_reg[0];
        t2    = sha256_pkg::big_sigma0(v_reg[0]) + maj;
        w_new = sha256_pkg::small_sigma1(sched_reg[14]) + sched_reg[9]
              + sha256_pkg::small_sigma0(sched_reg[1]) + sched_reg[0];
    end

    // next values of block, counters, schedule, working variables, chaining state and digest
    always_comb
    begin
        blk_next    = blk_reg;
        h_next      = h_reg;
        count_next  = count_reg;
        slot_next   = slot_reg;
        pos_next    = pos_reg;
        sched_next  = sched_reg;
        v_next      = v_reg;
        digest_next = digest_reg;

        if (cmd.wr_word)
        begin
            blk_next[slot_reg] = message_word;
            slot_next          = slot_reg + 1'b1;
        end
        if (cmd.wr_last)
        begin
            blk_next[slot_reg] = message_word & keep_mask;
            pos_next           = {slot_reg, 5'b0} + {4'b0, bits_clip};
        end
        if (cmd.wr_word || cmd.wr_last)
        begin
            // saturating bit count
            count_next = count_sum[sha256_pkg::COUNT_W] ? {sha256_pkg::COUNT_W{1'b1}}
                                                         : count_sum[sha256_pkg::COUNT_W-1:0];
        end
        if (cmd.pad)
        begin
            blk_next[pos_reg[8:5]] = blk_reg[pos_reg[8:5]] | (32'h8000_0000 >> pos_reg[4:0]);
        end
        if (cmd.len)
        begin
            blk_next[14] = count_reg[63:32];
            blk_next[15] = count_reg[31:0];
        end
        if (cmd.load)
        begin
            sched_next = blk_reg;
            v_next     = h_reg;
        end
        if (cmd.round)
        begin
            for (int i = 0; i < N - 1; i++)
            begin
                sched_next[i] = sched_reg[i + 1];
            end
            sched_next[N-1] = w_new;
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end
        if (cmd.fold || cmd.fold_final)
        begin
            for (int i = 0; i < N; i++)
            begin
                blk_next[i] = '0;
            end
            pos_next = '0;
        end
        if (cmd.fold)
        begin
            for (int i = 0; i < C; i++)
            begin
                h_next[i] = h_reg[i] + v_reg[i];
            end
        end
        if (cmd.fold_final)
        begin
            // hand out the digest and restart the chain
            for (int i = 0; i < C; i++)
            begin
                digest_next[i] = h_reg[i] + v_reg[i];
                h_next[i]      = sha256_pkg::H_INIT[i];
            end
            count_next = '0;
            slot_next  = '0;
        end
    end

    // control state and chaining state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                blk_reg[i] <= '0;
            end
            for (int i = 0; i < C; i++)
            begin
                h_reg[i] <= sha256_pkg::H_INIT[i];
            end
            count_reg <= '0;
            slot_reg  <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            blk_reg   <= blk_next;
            h_reg     <= h_next;
            count_reg <= count_next;
            slot_reg  <= slot_next;
            pos_reg   <= pos_next;
        end
    end

    // working variables, schedule and digest
    always_ff @(posedge clk)
    begin
        sched_reg  <= sched_next;
        v_reg      <= v_next;
        digest_reg <= digest_next;
    end

    assign status.slot_last = (slot_reg == sha256_pkg::LAST_SLOT);
    assign status.pos_full  = pos_reg[9];
    assign status.pos_high  = (pos_reg >= sha256_pkg::LEN_POS);
    assign digest           = digest_reg;

endmodule

// File: design/sha256_chk.sv
// port-level checker of the sha-256 hash engine and its bind
module sha256_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [sha256_pkg::WORD_W-1:0] message_word,
    input logic [sha256_pkg::BITS_W-1:0] word_bits,
    input logic                          last_word,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [sha256_pkg::WORD_W-1:0] digest_0,
    input logic [sha256_pkg::WORD_W-1:0] digest_1,
    input logic [sha256_pkg::WORD_W-1:0] digest_2,
    input logic [sha256_pkg::WORD_W-1:0] digest_3,
    input logic [sha256_pkg::WORD_W-1:0] digest_4,
    input logic [sha256_pkg::WORD_W-1:0] digest_5,
    input logic [sha256_pkg::WORD_W-1:0] digest_6,
    input logic [sha256_pkg::WORD_W-1:0] digest_7
);

    // a stalled digest stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
    else $error("digest withdrawn while stalled");

    // a stalled digest keeps the value of its first and last words
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(digest_0) && $stable(digest_7))
    else $error("digest changed while stalled");

    // the last word of a message always starts padding work
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_word |=> !in_ready)
    else $error("input still open after last word");

    // a digest only appears out of a compression, never from the idle state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
    else $error("digest appeared without a compression");

    // no digest can follow a last word in the very next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_word && !out_valid |=> !out_valid)
    else $error("digest too early after last word");

endmodule

bind sha256_hash_engine sha256_chk u_sha256_chk (.*);
